// File: rtl/md5de_pkg.sv
// ----------------------------------------------------------------------------
// md5de_pkg
// Shared types and constants of the MD5 digest engine: the four-word working
// state, the initial chaining value, and the step constant and rotate tables.
// ----------------------------------------------------------------------------
package md5de_pkg;

    // Four 32-bit words A, B, C, D of the working or chaining state
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } abcd_t;

    localparam abcd_t CHAIN_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    // Additive constant of each of the 64 steps
    function automatic logic [31:0] step_const(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotate amount, indexed by round and step within a group of four
    function automatic logic [4:0] step_rot(input logic [3:0] idx);
        logic [4:0] s;
        case (idx)
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/md5de_step.sv
// ----------------------------------------------------------------------------
// md5de_step
// One MD5 step: round function, additions and rotate, giving the next
// working state from the current one, the message word and the step number.
// ----------------------------------------------------------------------------
module md5de_step (
    input  md5de_pkg::abcd_t cur,
    input  logic [31:0]      msg,
    input  logic [5:0]       step,
    output md5de_pkg::abcd_t nxt
);

    logic [31:0] f;
    logic [31:0] t;
    logic [31:0] rot;
    logic [4:0]  s;

    // Pick the round function
    always_comb
    begin
        case (step[5:4])
            2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
            2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
            2'd2:    f = cur.b ^ cur.c ^ cur.d;
            2'd3:    f = cur.c ^ (cur.b | ~cur.d);
            default: f = 32'h0;
        endcase
    end

    // Sum, rotate and shuffle the words
    always_comb
    begin
        s   = md5de_pkg::step_rot({step[5:4], step[1:0]});
        t   = cur.a + f + msg + md5de_pkg::step_const(step);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
        nxt.a = cur.d;
        nxt.b = cur.b + rot;
        nxt.c = cur.b;
        nxt.d = cur.c;
    end

endmodule

// File: rtl/md5_digest_engine.sv
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 digest over a stream of little-endian message words, one step a cycle.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on data_valid / data_stall with data_word, valid_bytes
// and is_last; a word is taken when data_valid is high and data_stall low.
// The bytes of a word are placed into the 64-byte block buffer in the cycle
// it is taken, so a word that neither fills the block nor is last does not
// stall the input. A word that fills the block starts a compression: 64
// steps through the shared step unit, then a fold into the chaining value,
// during which data_stall is high.
// A word with is_last runs the padding block (after the data block when it
// also fills one), a second padding block when the fill was 56 or more,
// then loads the digest register. The digest appears on digest_low /
// digest_high with digest_valid and holds while digest_stall is high; new
// words are taken meanwhile, and only the next digest waits for the
// register to free up.
// After the digest, chaining value, fill and byte count return to their
// initial values. Reset clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module md5_digest_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        is_last,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD_A,
        BLK_PAD_B
    } blk_kind_t;

    state_t             state_reg, state_next;
    blk_kind_t          kind_reg, kind_next;
    logic [5:0]         step_reg, step_next;
    md5de_pkg::abcd_t   work_reg, work_next;
    md5de_pkg::abcd_t   chain_reg, chain_next;
    logic [5:0]         fill_reg, fill_next;
    logic [31:0]        total_reg, total_next;
    logic [31:0]        word_reg, word_next;
    logic [2:0]         count_reg, count_next;
    logic [5:0]         start_reg, start_next;
    logic               last_reg, last_next;
    logic               digest_valid_reg, digest_valid_next;
    logic [63:0]        digest_low_reg, digest_low_next;
    logic [63:0]        digest_high_reg, digest_high_next;

    logic [3:0][7:0]    buffer_reg [16];

    logic               accept;
    logic [2:0]         in_count;
    logic [6:0]         fill_sum;
    logic [3:0]         g_idx;
    logic [31:0]        msg_word;
    md5de_pkg::abcd_t   step_out;
    md5de_pkg::abcd_t   chain_sum;
    logic               slot_free;

    logic [3:0]         wr_en;
    logic [3:0][5:0]    wr_pos;
    logic [3:0][7:0]    wr_byte;

    // Build one message word of the block being compressed
    function automatic logic [31:0] fetch_word(
        input logic [3:0]  g,
        input blk_kind_t   kind,
        input logic [5:0]  fill,
        input logic [31:0] total,
        input logic [31:0] raw
    );
        logic [31:0] res;
        logic [5:0]  pos;
        logic        len_here;
        res      = 32'h0;
        pos      = 6'd0;
        len_here = 1'b0;
        case (kind)
            BLK_DATA:
            begin
                res = raw;
            end
            BLK_PAD_A:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    pos = {g, 2'(k)};
                    if (pos < fill)
                        res[8*k +: 8] = raw[8*k +: 8];
                    else if (pos == fill)
                        res[8*k +: 8] = 8'h80;
                end
                len_here = (fill < 6'd56);
            end
            BLK_PAD_B:
            begin
                len_here = 1'b1;
            end
            default:
            begin
                res = raw;
            end
        endcase
        if (len_here && g == 4'd14)
            res = {total[28:0], 3'b000};
        else if (len_here && g == 4'd15)
            res = {29'h0, total[31:29]};
        return res;
    endfunction

    assign data_stall = (state_reg != ST_IDLE);
    assign accept     = data_valid && !data_stall;
    assign in_count   = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    assign fill_sum   = {1'b0, fill_reg} + {4'b0000, in_count};
    assign slot_free  = !digest_valid_reg || !digest_stall;

    // Message word index of the current step
    always_comb
    begin
        case (step_reg[5:4])
            2'd0:    g_idx = step_reg[3:0];
            2'd1:    g_idx = 4'(step_reg[3:0] * 4'd5 + 4'd1);
            2'd2:    g_idx = 4'(step_reg[3:0] * 4'd3 + 4'd5);
            2'd3:    g_idx = 4'(step_reg[3:0] * 4'd7);
            default: g_idx = step_reg[3:0];
        endcase
    end

    assign msg_word = fetch_word(g_idx, kind_reg, fill_reg, total_reg, buffer_reg[g_idx]);

    md5de_step u_step (
        .cur  (work_reg),
        .msg  (msg_word),
        .step (step_reg),
        .nxt  (step_out)
    );

    // Fold the working state into the chaining value
    always_comb
    begin
        chain_sum.a = chain_reg.a + work_reg.a;
        chain_sum.b = chain_reg.b + work_reg.b;
        chain_sum.c = chain_reg.c + work_reg.c;
        chain_sum.d = chain_reg.d + work_reg.d;
    end

    // Place bytes: a new word up to the block end, or its spill after folding
    always_comb
    begin
        logic [6:0] pos;
        for (int k = 0; k < 4; k++)
        begin
            if (state_reg == ST_FOLD)
            begin
                pos        = {1'b0, start_reg} + 7'(k);
                wr_en[k]   = (kind_reg == BLK_DATA) && (3'(k) < count_reg) && pos[6];
                wr_byte[k] = word_reg[8*k +: 8];
            end
            else
            begin
                pos        = {1'b0, fill_reg} + 7'(k);
                wr_en[k]   = accept && (3'(k) < in_count) && !pos[6];
                wr_byte[k] = data_word[8*k +: 8];
            end
            wr_pos[k] = pos[5:0];
        end
    end

    // Write the block buffer
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (wr_en[k])
                buffer_reg[wr_pos[k][5:2]][wr_pos[k][1:0]] <= wr_byte[k];
        end
    end

    // Sequence words, steps, padding and the digest
    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        step_next         = step_reg;
        work_next         = work_reg;
        chain_next        = chain_reg;
        fill_next         = fill_reg;
        total_next        = total_reg;
        word_next         = word_reg;
        count_next        = count_reg;
        start_next        = start_reg;
        last_next         = last_reg;
        digest_valid_next = digest_valid_reg;
        digest_low_next   = digest_low_reg;
        digest_high_next  = digest_high_reg;

        // drop the digest once taken
        if (digest_valid_reg && !digest_stall)
            digest_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    word_next  = data_word;
                    count_next = in_count;
                    start_next = fill_reg;
                    last_next  = is_last;
                    fill_next  = fill_sum[5:0];
                    total_next = total_reg + {29'h0, in_count};
                    step_next  = 6'd0;
                    work_next  = chain_reg;
                    if (fill_sum[6])
                    begin
                        kind_next  = BLK_DATA;
                        state_next = ST_ROUND;
                    end
                    else if (is_last)
                    begin
                        kind_next  = BLK_PAD_A;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                work_next = step_out;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                chain_next = chain_sum;
                work_next  = chain_sum;
                step_next  = 6'd0;
                case (kind_reg)
                    BLK_DATA:
                    begin
                        kind_next  = BLK_PAD_A;
                        state_next = last_reg ? ST_ROUND : ST_IDLE;
                    end
                    BLK_PAD_A:
                    begin
                        kind_next  = BLK_PAD_B;
                        state_next = (fill_reg >= 6'd56) ? ST_ROUND : ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT:
            begin
                // hold until the digest register is free
                if (slot_free)
                begin
                    digest_valid_next = 1'b1;
                    digest_low_next   = {chain_reg.b, chain_reg.a};
                    digest_high_next  = {chain_reg.d, chain_reg.c};
                    chain_next        = md5de_pkg::CHAIN_INIT;
                    fill_next         = 6'd0;
                    total_next        = 32'h0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            kind_reg         <= BLK_DATA;
            step_reg         <= 6'd0;
            work_reg         <= md5de_pkg::CHAIN_INIT;
            chain_reg        <= md5de_pkg::CHAIN_INIT;
            fill_reg         <= 6'd0;
            total_reg        <= 32'h0;
            word_reg         <= 32'h0;
            last_reg         <= 1'b0;
            count_reg        <= 3'd0;
            start_reg        <= 6'd0;
            digest_valid_reg <= 1'b0;
            digest_low_reg   <= 64'h0;
            digest_high_reg  <= 64'h0;
        end
        else
        begin
            state_reg        <= state_next;
            kind_reg         <= kind_next;
            step_reg         <= step_next;
            work_reg         <= work_next;
            chain_reg        <= chain_next;
            fill_reg         <= fill_next;
            total_reg        <= total_next;
            word_reg         <= word_next;
            last_reg         <= last_next;
            count_reg        <= count_next;
            start_reg        <= start_next;
            digest_valid_reg <= digest_valid_next;
            digest_low_reg   <= digest_low_next;
            digest_high_reg  <= digest_high_next;
        end
    end

    assign digest_valid = digest_valid_reg;
    assign digest_low   = digest_low_reg;
    assign digest_high  = digest_high_reg;

    // A word that completes the block starts a compression from step zero
    a_full_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fill_sum[6]) |=> (state_reg == ST_ROUND && step_reg == 6'd0
                                     && kind_reg == BLK_DATA))
        else $error("full block did not start a compression");

    // The last step always folds next
    a_last_folds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && step_reg == 6'd63) |=> (state_reg == ST_FOLD))
        else $error("compression did not fold after the last step");

    // The second padding block only follows a fill too long for the length
    a_pad_b_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && kind_reg == BLK_PAD_B) |-> (fill_reg >= 6'd56))
        else $error("second padding block with a short fill");

    // Issuing a digest restarts the message state
    a_emit_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free) |=>
            (digest_valid && fill_reg == 6'd0 && total_reg == 32'h0
             && state_reg == ST_IDLE))
        else $error("digest issue did not restart the message");

endmodule

// File: tb/sv/md5_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_digest_checker
// Watches both channels of the MD5 digest engine. Every word taken on the
// input side is absorbed into a digest calculator of its own; a final word
// queues the digest it must produce. Every digest taken on the output side
// is compared with the oldest queued one, low and high halves apart.
// ----------------------------------------------------------------------------
module md5_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        is_last,
    input  logic        digest_valid,
    input  logic        digest_stall,
    input  logic [63:0] digest_low,
    input  logic [63:0] digest_high,
    output int unsigned outstanding,
    output int unsigned mismatches
);

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LENGTH_POS = 56;
    localparam int unsigned WORD_BYTES_MAX = 4;

    localparam logic [31:0] ADD_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned SHIFT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } digest_t;

    // Calculator state: chaining words, gathered bytes, fill and message length
    logic [31:0] chain [4];
    logic [7:0]  gathered [64];
    logic [7:0]  frame [64];
    int unsigned fill;
    logic [31:0] byte_total;
    digest_t     digests_due [$];
    digest_t     oldest_due;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Run the 64 steps over frame and fold the result into the chaining words
    function automatic void compress_frame();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t, nb;
        int unsigned i, g;
        for (i = 0; i < 16; i++)
            w[i] = {frame[4*i+3], frame[4*i+2], frame[4*i+1], frame[4*i]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = 5 * i + 1;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = 3 * i + 5;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = 7 * i;
                end
            endcase
            t  = a + f + w[g % 16] + ADD_K[i];
            nb = b + rotl(t, SHIFT_AMT[(i / 16) * 4 + i % 4]);
            a  = d;
            d  = c;
            c  = b;
            b  = nb;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endfunction

    function automatic void restart_message();
        chain[0]   = IV_A;
        chain[1]   = IV_B;
        chain[2]   = IV_C;
        chain[3]   = IV_D;
        fill       = 0;
        byte_total = '0;
    endfunction

    // Close the message with marker, zeros and bit length, then queue the digest
    function automatic void close_message();
        logic [63:0] bit_len;
        digest_t     dg;
        int unsigned i;
        bit_len = {29'd0, byte_total, 3'd0};
        for (i = 0; i < BLOCK_BYTES; i++)
            frame[i] = (i < fill) ? gathered[i] : 8'h00;
        frame[fill] = PAD_MARK;
        if (fill >= LENGTH_POS)
        begin
            compress_frame();
            for (i = 0; i < BLOCK_BYTES; i++)
                frame[i] = 8'h00;
        end
        for (i = 0; i < 8; i++)
            frame[LENGTH_POS + i] = bit_len[8*i +: 8];
        compress_frame();
        dg.low  = {chain[1], chain[0]};
        dg.high = {chain[3], chain[2]};
        digests_due.push_back(dg);
        restart_message();
    endfunction

    // Append the valid bytes of one word, compressing each block as it fills
    function automatic void absorb_word(input logic [31:0] word, input logic [2:0] nvalid,
                                        input logic last);
        int unsigned n, i, j;
        n = (nvalid > WORD_BYTES_MAX) ? WORD_BYTES_MAX : nvalid;
        for (i = 0; i < n; i++)
        begin
            gathered[fill] = word[8*i +: 8];
            fill++;
            if (fill == BLOCK_BYTES)
            begin
                for (j = 0; j < BLOCK_BYTES; j++)
                    frame[j] = gathered[j];
                compress_frame();
                fill = 0;
            end
        end
        byte_total = byte_total + n;
        if (last)
            close_message();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  digest mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Compare taken digests first, then absorb the word taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digests_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (digest_valid && !digest_stall)
            begin
                if (digests_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected digest %h %h",
                                              digest_high, digest_low));
                end
                else
                begin
                    oldest_due = digests_due.pop_front();
                    if (digest_low !== oldest_due.low)
                        report_mismatch($sformatf("low half %h, want %h",
                                                  digest_low, oldest_due.low));
                    if (digest_high !== oldest_due.high)
                        report_mismatch($sformatf("high half %h, want %h",
                                                  digest_high, oldest_due.high));
                end
            end
            if (data_valid && !data_stall)
                absorb_word(data_word, valid_bytes, is_last);
            outstanding <= digests_due.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the MD5 digest engine. Sends directed messages
// (empty, short, unaligned, oversized byte counts, a fill that needs a
// second padding block) and then random messages of random length, with
// random idle cycles on both sides, idle-free stretches and one long output
// hold that backs the engine up. Checking is done by md5_digest_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned WORDS_TARGET = 450;
    localparam int unsigned HOLD_AFTER   = 8;
    localparam int unsigned HOLD_CYCLES  = 1500;
    localparam int unsigned DRAIN_CYCLES = 200;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        data_valid   = 1'b0;
    logic [31:0] data_word    = '0;
    logic [2:0]  valid_bytes  = '0;
    logic        is_last      = 1'b0;
    logic        digest_stall = 1'b0;
    wire         data_stall;
    wire         digest_valid;
    wire  [63:0] digest_low;
    wire  [63:0] digest_high;

    int unsigned digests_pending;
    int unsigned mismatches;
    int unsigned words_sent = 0;
    bit          steady     = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    md5_digest_engine i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_word    (data_word),
        .valid_bytes  (valid_bytes),
        .is_last      (is_last),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_low   (digest_low),
        .digest_high  (digest_high)
    );

    md5_digest_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_word    (data_word),
        .valid_bytes  (valid_bytes),
        .is_last      (is_last),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_low   (digest_low),
        .digest_high  (digest_high),
        .outstanding  (digests_pending),
        .mismatches   (mismatches)
    );

    // Offer one word after a random gap and hold it until the engine takes it
    task automatic offer_word(input logic [31:0] w, input logic [2:0] nvalid,
                              input logic last);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_valid  <= 1'b1;
        data_word   <= w;
        valid_bytes <= nvalid;
        is_last     <= last;
        do
            @(posedge clk);
        while (data_stall !== 1'b0);
        words_sent++;
    endtask

    // Accept digests with random stalls; hold off for a long stretch once
    initial
    begin
        int unsigned gap;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == HOLD_AFTER)
            begin
                digest_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                digest_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            digest_stall <= 1'b0;
            do
                @(posedge clk);
            while (digest_valid !== 1'b1);
            taken++;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int unsigned nwords;
        int unsigned k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message: marker and length only
        offer_word(32'h00000000, 3'd0, 1'b1);
        // three-byte message
        offer_word(32'h00636261, 3'd3, 1'b1);
        // short and empty words mid-message, oversized counts clamp to four
        offer_word(32'hffffffff, 3'd1, 1'b0);
        offer_word(32'h0000a5c3, 3'd2, 1'b0);
        offer_word(32'hdeadbeef, 3'd0, 1'b0);
        offer_word(32'hffffffff, 3'd7, 1'b0);
        offer_word(32'h12345678, 3'd6, 1'b0);
        offer_word(32'h87654321, 3'd5, 1'b1);
        // fill of exactly 56 leaves no room for the length: two padding blocks
        for (k = 0; k < 14; k++)
            offer_word($urandom, 3'd4, 1'b0);
        offer_word(32'hffffffff, 3'd0, 1'b1);

        // random messages, mostly full words, some crossing several blocks
        while (words_sent < WORDS_TARGET)
        begin
            steady = ($urandom_range(0, 4) == 0);
            nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                 : $urandom_range(1, 16);
            for (k = 1; k < nwords; k++)
                offer_word($urandom,
                           ($urandom_range(0, 9) < 8) ? 3'd4 : 3'($urandom_range(0, 7)),
                           1'b0);
            offer_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
        end
        steady = 1'b0;
        data_valid <= 1'b0;

        // drain outstanding digests, then let the engine settle
        do
            @(posedge clk);
        while (digests_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
